// File: sv/sad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sad_pkg;

  // Default number of CORDIC cells in the chain
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // Coordinate, difference, product and sum widths
  localparam int unsigned CW = 32;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned MW = SW - 1;
  localparam int unsigned LZW = $clog2(MW + 1);

  // Normalised operand width and its lowest bit in the shifted magnitude
  localparam int unsigned NW = 60;
  localparam int unsigned NORM_LSB = MW - NW;

  // CORDIC datapath: x and y signed with headroom for the gain, angle in Q8.24
  localparam int unsigned XW = NW + 3;
  localparam int unsigned ZW = 32;
  localparam int unsigned AW = 24;

  localparam logic signed [ZW-1:0] ANGLE_LIM_Q24 = 32'sd1509949440;
  localparam logic [ZW-1:0] ANGLE_HALF_Q24 = 32'd3019898880;
  localparam logic [ZW-1:0] ROUND_Q24 = 32'd128;
  localparam logic [AW-1:0] RIGHT_ANGLE_Q16 = 24'd5898240;
  localparam logic [AW-1:0] ANGLE_MAX_Q16 = 24'd11796480;

  typedef enum logic [1:0] {
    CASE_GENERAL  = 2'd0,
    CASE_PARALLEL = 2'd1,
    CASE_PERP     = 2'd2,
    CASE_DEGEN    = 2'd3
  } case_t;

  typedef struct packed {
    logic signed [CW-1:0] ax0;
    logic signed [CW-1:0] ay0;
    logic signed [CW-1:0] ax1;
    logic signed [CW-1:0] ay1;
    logic signed [CW-1:0] bx0;
    logic signed [CW-1:0] by0;
    logic signed [CW-1:0] bx1;
    logic signed [CW-1:0] by1;
  } in_word_t;

  typedef struct packed {
    logic [AW-1:0] angle_deg;
    logic [1:0]    case_code;
  } out_word_t;

  // Word handed from cell to cell along the CORDIC chain
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 dot_neg;
    case_t                code;
  } cord_t;

  // atan(2^-i) in degrees, Q8.24, rounded
  function automatic logic signed [ZW-1:0] atan_deg_q24(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'sd754974720;
      5'd1:    v = 32'sd445687602;
      5'd2:    v = 32'sd235489088;
      5'd3:    v = 32'sd119537938;
      5'd4:    v = 32'sd60000934;
      5'd5:    v = 32'sd30029717;
      5'd6:    v = 32'sd15018523;
      5'd7:    v = 32'sd7509720;
      5'd8:    v = 32'sd3754917;
      5'd9:    v = 32'sd1877466;
      5'd10:   v = 32'sd938734;
      5'd11:   v = 32'sd469367;
      5'd12:   v = 32'sd234684;
      5'd13:   v = 32'sd117342;
      5'd14:   v = 32'sd58671;
      5'd15:   v = 32'sd29335;
      5'd16:   v = 32'sd14668;
      5'd17:   v = 32'sd7334;
      5'd18:   v = 32'sd3667;
      5'd19:   v = 32'sd1833;
      5'd20:   v = 32'sd917;
      5'd21:   v = 32'sd458;
      5'd22:   v = 32'sd229;
      5'd23:   v = 32'sd115;
      5'd24:   v = 32'sd57;
      5'd25:   v = 32'sd29;
      5'd26:   v = 32'sd14;
      5'd27:   v = 32'sd7;
      5'd28:   v = 32'sd4;
      5'd29:   v = 32'sd2;
      5'd30:   v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/sad_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sad_front
  import sad_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cord_t         out_cd
);

  localparam int unsigned NSTG = 6;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  // Stage 1: direction vectors
  logic signed [DW-1:0] dxa_r, dya_r, dxb_r, dyb_r;
  // Stage 2: products and degenerate flag
  logic signed [PW-1:0] p_ab_r, p_ba_r, p_xx_r, p_yy_r;
  logic                 degen2_r;
  // Stage 3: cross and dot
  logic signed [SW-1:0] cross_r, dot_r;
  logic                 degen3_r;
  // Stage 4: magnitudes and case
  logic [MW-1:0]        mc4_r, md4_r;
  logic                 neg4_r;
  case_t                code4_r;
  // Stage 5: leading zero count
  logic [MW-1:0]        mc5_r, md5_r;
  logic                 neg5_r;
  case_t                code5_r;
  logic [LZW-1:0]       lz5_r;
  // Stage 6: normalised word
  cord_t                cd_r;

  logic [LZW-1:0] lz_nxt;
  logic [MW-1:0]  mc_sh, md_sh;
  case_t          code_nxt;

  // A stage loads when it is empty or its word moves on
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];
  assign out_cd    = cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Classify the item: degenerate first, then parallel, then perpendicular
  always_comb begin
    if (degen3_r) begin
      code_nxt = CASE_DEGEN;
    end else if (cross_r == '0) begin
      code_nxt = CASE_PARALLEL;
    end else if (dot_r == '0) begin
      code_nxt = CASE_PERP;
    end else begin
      code_nxt = CASE_GENERAL;
    end
  end

  // Count leading zeros of the larger magnitude via the OR of both
  always_comb begin
    logic [MW-1:0] both;
    both   = mc4_r | md4_r;
    lz_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (both[i]) begin
        lz_nxt = LZW'(MW - 1 - i);
      end
    end
  end

  // Put the top bit of the larger magnitude at the top of the word
  assign mc_sh = mc5_r << lz5_r;
  assign md_sh = md5_r << lz5_r;

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      dxa_r <= DW'(in_word.ax1) - DW'(in_word.ax0);
      dya_r <= DW'(in_word.ay1) - DW'(in_word.ay0);
      dxb_r <= DW'(in_word.bx1) - DW'(in_word.bx0);
      dyb_r <= DW'(in_word.by1) - DW'(in_word.by0);
    end
    if (adv[1] && v_r[0]) begin
      p_ab_r   <= PW'(dxa_r) * PW'(dyb_r);
      p_ba_r   <= PW'(dya_r) * PW'(dxb_r);
      p_xx_r   <= PW'(dxa_r) * PW'(dxb_r);
      p_yy_r   <= PW'(dya_r) * PW'(dyb_r);
      degen2_r <= ((dxa_r == '0) && (dya_r == '0)) || ((dxb_r == '0) && (dyb_r == '0));
    end
    if (adv[2] && v_r[1]) begin
      cross_r  <= SW'(p_ab_r) - SW'(p_ba_r);
      dot_r    <= SW'(p_xx_r) + SW'(p_yy_r);
      degen3_r <= degen2_r;
    end
    if (adv[3] && v_r[2]) begin
      mc4_r   <= cross_r[SW-1] ? MW'(-cross_r) : MW'(cross_r);
      md4_r   <= dot_r[SW-1] ? MW'(-dot_r) : MW'(dot_r);
      neg4_r  <= dot_r[SW-1];
      code4_r <= code_nxt;
    end
    if (adv[4] && v_r[3]) begin
      mc5_r   <= mc4_r;
      md5_r   <= md4_r;
      neg5_r  <= neg4_r;
      code5_r <= code4_r;
      lz5_r   <= lz_nxt;
    end
    if (adv[5] && v_r[4]) begin
      cd_r.x       <= XW'(md_sh[MW-1:NORM_LSB]);
      cd_r.y       <= XW'(mc_sh[MW-1:NORM_LSB]);
      cd_r.z       <= '0;
      cd_r.dot_neg <= neg5_r;
      cd_r.code    <= code5_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/sad_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sad_cell
  import sad_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire cord_t in_cd,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cord_t      out_cd
);

  logic  valid_r;
  cord_t cd_r;
  cord_t cd_nxt;

  // One micro-rotation towards the x axis, shift fixed by the cell's place
  always_comb begin
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] a;
    xs     = in_cd.x >>> STEP;
    ys     = in_cd.y >>> STEP;
    a      = atan_deg_q24(5'(STEP));
    cd_nxt = in_cd;
    if (!in_cd.y[XW-1]) begin
      cd_nxt.x = in_cd.x + ys;
      cd_nxt.y = in_cd.y - xs;
      cd_nxt.z = in_cd.z + a;
    end else begin
      cd_nxt.x = in_cd.x - ys;
      cd_nxt.y = in_cd.y + xs;
      cd_nxt.z = in_cd.z - a;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_cd    = cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Hold the word until the next cell takes it
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cd_r <= cd_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/sad_post.sv
`timescale 1ns / 1ps
`default_nettype none

module sad_post
  import sad_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire cord_t in_cd,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_word_t  out_word
);

  logic      valid_r;
  out_word_t word_r;
  out_word_t word_nxt;

  // Clamp to 0..90, mirror for an obtuse angle, round to Q8.16
  always_comb begin
    logic [ZW-1:0] zc;
    logic [ZW-1:0] zm;
    logic [ZW-1:0] zr;
    if (in_cd.z[ZW-1]) begin
      zc = '0;
    end else if (in_cd.z > ANGLE_LIM_Q24) begin
      zc = ANGLE_LIM_Q24;
    end else begin
      zc = in_cd.z;
    end
    zm = in_cd.dot_neg ? (ANGLE_HALF_Q24 - zc) : zc;
    zr = zm + ROUND_Q24;
    word_nxt.case_code = in_cd.code;
    case (in_cd.code)
      CASE_GENERAL: word_nxt.angle_deg = zr[ZW-1:ZW-AW];
      CASE_PERP:    word_nxt.angle_deg = RIGHT_ANGLE_Q16;
      default:      word_nxt.angle_deg = '0;
    endcase
  end

  assign in_ready  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Hold the result word while the receiver stalls
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/segment_angle_degrees_top.sv
// Angle between the direction vectors of two segments.
//
// Input channel (in_valid, in_stall, in_data): one word carries the four
// endpoints ax0..by1 in signed Q15.16. A word is taken at a rising edge with
// in_valid high and in_stall low.
// Result channel (out_valid, out_stall, out_data): one word per input word,
// angle_deg in unsigned Q8.16 (0 to 180) and case_code (general, parallel,
// perpendicular, degenerate), in input order.
//
// Throughput is one word per cycle while out_stall is low. The path holds
// six front stages (differences, 33x33 products, cross/dot sums,
// magnitudes, leading zero count, normalising shift), one cell per CORDIC
// iteration, and the output register.
// Every stage holds a valid bit; a stage refills whenever it is empty, so a
// stalled receiver backs the chain up one stage at a time and in_stall only
// rises once every stage holds a word. Synchronous reset clears all valid
// bits; nothing is in flight after reset.
`timescale 1ns / 1ps
`default_nettype none

module segment_angle_degrees_top
  import sad_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_data
);

  logic                 front_ready;
  logic [CORDIC_STEPS:0] chain_v;
  logic [CORDIC_STEPS:0] chain_rdy;
  cord_t                chain_cd [CORDIC_STEPS+1];

  assign in_stall = !front_ready;

  // Form, classify and normalise the vectors
  sad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .in_word   (in_data),
    .out_valid (chain_v[0]),
    .out_ready (chain_rdy[0]),
    .out_cd    (chain_cd[0])
  );

  // Rotate through the row of CORDIC cells
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    sad_cell #(
      .STEP (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[g]),
      .in_ready  (chain_rdy[g]),
      .in_cd     (chain_cd[g]),
      .out_valid (chain_v[g+1]),
      .out_ready (chain_rdy[g+1]),
      .out_cd    (chain_cd[g+1])
    );
  end

  // Finish the angle and drive the result word
  sad_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_v[CORDIC_STEPS]),
    .in_ready  (chain_rdy[CORDIC_STEPS]),
    .in_cd     (chain_cd[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_data)
  );

endmodule

`default_nettype wire

// File: sv/sad_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sad_checker
  import sad_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  // A stalled result word stays and holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word dropped or changed");

  // The angle never leaves 0 to 180 degrees
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.angle_deg <= ANGLE_MAX_Q16)
    else $error("angle beyond 180 degrees");

  // Special cases carry their fixed angles
  a_special: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_data.case_code != CASE_PARALLEL && out_data.case_code != CASE_DEGEN)
        || out_data.angle_deg == '0) &&
      (out_data.case_code != CASE_PERP || out_data.angle_deg == RIGHT_ANGLE_Q16))
    else $error("special case with wrong angle");

endmodule

bind segment_angle_degrees_top sad_checker u_sad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
